>>> hdl/urep_pkg.sv
`timescale 1ns / 1ps
package urep_pkg;

  localparam int URP_QUEUE_DEPTH = 4;
  localparam int SER_SLOTS = 5;

  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_TAG = 8'h80;
  localparam logic [7:0] LEAD2 = 8'hC0;
  localparam logic [7:0] LEAD3 = 8'hE0;
  localparam logic [7:0] LEAD4 = 8'hF0;

  localparam logic [1:0] LEN1 = 2'd0;
  localparam logic [1:0] LEN2 = 2'd1;
  localparam logic [1:0] LEN3 = 2'd2;
  localparam logic [1:0] LEN4 = 2'd3;

  // one closed group, optionally followed by a one-byte group
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0] len_m1;
    logic [31:0] rnd;
    logic has_tail;
    logic [6:0] tail;
    logic final_flag;
  } job_t;

  // residue modulo 15 by nibble folding
  function automatic logic [3:0] mod15(input logic [27:0] v);
    logic [6:0] s;
    logic [4:0] t;
    s = '0;
    for (int i = 0; i < 7; i++) begin
      s = s + {3'b000, v[i*4 +: 4]};
    end
    t = {2'b00, s[6:4]} + {1'b0, s[3:0]};
    if (t >= 5'd15) begin
      t = t - 5'd15;
    end
    return t[3:0];
  endfunction

endpackage

>>> hdl/utf8_sequence_repair_core.sv
`timescale 1ns / 1ps
// utf8 sequence repair: takes a string one byte per beat and gives back
// well-formed utf-8 groups, one byte per output beat
// input channel: in_valid/in_ready with in_byte, random_word, string_end
// output channel: out_valid/out_ready with out_byte, run_last, final_byte
// a group's bytes come out when the group closes: on the next lead byte,
// on the fourth byte, or on the beat that carries string_end
// a closed group moves from the queue through the gather register to the
// serializer, which offers one byte per cycle while out_ready is high
// throughput: one input beat per cycle while the queue has room; the
// serializer emits one byte per cycle, so sustained rate is one byte per
// cycle for strings that keep their length, set by the output byte lane
// a queue of QUEUE_DEPTH closed groups sits between the grouping front end
// and the repair/serializer back end; in_ready drops only when it is full
// stalling out_ready backs up the serializer, then the queue, then input
// reset clears the open group, the queue and the output stage
module utf8_sequence_repair_core import urep_pkg::*; #(
  parameter int QUEUE_DEPTH = URP_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic [31:0] random_word,
  input  logic        string_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        run_last,
  output logic        final_byte
);

  logic q_full;
  logic q_push;
  job_t q_push_job;
  logic q_pop;
  logic q_valid;
  job_t q_job;

  urep_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .random_word (random_word),
    .string_end  (string_end),
    .q_full      (q_full),
    .push        (q_push),
    .push_job    (q_push_job)
  );

  urep_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_job  (q_push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_job   (q_job)
  );

  urep_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_job      (q_job),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .final_byte (final_byte)
  );

endmodule

>>> hdl/urep_front.sv
`timescale 1ns / 1ps
module urep_front import urep_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic [31:0] random_word,
  input  logic        string_end,
  input  logic        q_full,
  output logic        push,
  output job_t        push_job
);

  logic [7:0] group_bytes [3];
  logic [1:0] group_count;
  logic [1:0] group_count_next;
  logic [31:0] group_random;
  logic [31:0] group_random_next;
  logic accept;
  logic cont;
  logic wr_en;
  logic [1:0] wr_idx;
  job_t job;

  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;
  assign cont = (in_byte & CONT_MASK) == CONT_TAG;

  always_comb begin
    job = '0;
    job.bytes[0] = group_bytes[0];
    job.bytes[1] = group_bytes[1];
    job.bytes[2] = group_bytes[2];
    job.bytes[3] = 8'h00;
    job.len_m1 = group_count - 2'd1;
    job.rnd = group_random;
    job.has_tail = 1'b0;
    job.tail = in_byte[6:0];
    job.final_flag = string_end;
    push = 1'b0;
    wr_en = 1'b0;
    wr_idx = group_count;
    group_count_next = group_count;
    group_random_next = group_random;
    if (accept) begin
      if (group_count != 2'd0 && cont) begin
        job.bytes[group_count] = in_byte;
        job.len_m1 = group_count;
        if (group_count == 2'd3 || string_end) begin
          push = 1'b1;
          group_count_next = 2'd0;
        end else begin
          wr_en = 1'b1;
          wr_idx = group_count;
          group_count_next = group_count + 2'd1;
        end
      end else begin
        group_random_next = random_word;
        if (group_count != 2'd0) begin
          push = 1'b1;
          job.has_tail = string_end;
        end else if (string_end) begin
          push = 1'b1;
          job.bytes[0] = in_byte;
          job.len_m1 = LEN1;
          job.rnd = random_word;
        end
        if (string_end) begin
          group_count_next = 2'd0;
        end else begin
          wr_en = 1'b1;
          wr_idx = 2'd0;
          group_count_next = 2'd1;
        end
      end
    end
  end

  assign push_job = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_count <= 2'd0;
      group_random <= '0;
    end else begin
      group_count <= group_count_next;
      group_random <= group_random_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      group_bytes[wr_idx] <= in_byte;
    end
  end

endmodule

>>> hdl/urep_queue.sv
`timescale 1ns / 1ps
module urep_queue import urep_pkg::*; #(
  parameter int DEPTH = URP_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output job_t pop_job
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full = count == FULL_CNT;
  assign pop_valid = count != '0;
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

>>> hdl/urep_back.sv
`timescale 1ns / 1ps
module urep_back import urep_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  job_t       q_job,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       final_byte
);

  // gather stage
  logic        rep_valid;
  logic [20:0] rep_c;
  logic [1:0]  rep_len_m1;
  logic [3:0]  rep_m2;
  logic [3:0]  rep_m3;
  logic [19:0] rep_rlo;
  logic        rep_has_tail;
  logic [6:0]  rep_tail;
  logic        rep_final;
  logic [20:0] gather_c;

  // serializer stage
  logic        ser_valid;
  logic [7:0]  ser_bytes [SER_SLOTS];
  logic [2:0]  ser_idx;
  logic [2:0]  ser_last;
  logic        ser_final;
  logic        ser_at_last;
  logic        ser_free;
  logic        ser_load;

  logic [10:0] v2;
  logic [15:0] x3;
  logic [15:0] v3;
  logic [20:0] v4;
  logic [20:0] c_fix;
  logic [7:0]  enc [4];
  logic [7:0]  ld_bytes [SER_SLOTS];
  logic [2:0]  ld_last;

  assign ser_at_last = ser_idx == ser_last;
  assign ser_free = !ser_valid || (out_ready && ser_at_last);
  assign ser_load = rep_valid && ser_free;
  assign q_pop = q_valid && (!rep_valid || ser_load);

  always_comb begin
    case (q_job.len_m1)
      LEN1: gather_c = {14'b0, q_job.bytes[0][6:0]};
      LEN2: gather_c = {10'b0, q_job.bytes[0][4:0], q_job.bytes[1][5:0]};
      LEN3: gather_c = {5'b0, q_job.bytes[0][3:0], q_job.bytes[1][5:0],
                        q_job.bytes[2][5:0]};
      LEN4: gather_c = {q_job.bytes[0][2:0], q_job.bytes[1][5:0],
                        q_job.bytes[2][5:0], q_job.bytes[3][5:0]};
      default: gather_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rep_valid <= 1'b0;
    end else if (q_pop) begin
      rep_valid <= 1'b1;
    end else if (ser_load) begin
      rep_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rep_c <= gather_c;
      rep_len_m1 <= q_job.len_m1;
      rep_m2 <= mod15({3'b000, q_job.rnd[31:7]});
      rep_m3 <= mod15({8'h00, q_job.rnd[31:12]});
      rep_rlo <= q_job.rnd[19:0];
      rep_has_tail <= q_job.has_tail;
      rep_tail <= q_job.tail;
      rep_final <= q_job.final_flag;
    end
  end

  // range repair, re-encoding and placement of the tail byte
  always_comb begin
    v2 = 11'h080 + {rep_m2, rep_rlo[6:0]};
    x3 = {rep_m3, rep_rlo[11:0]};
    v3 = (x3 >= 16'hD000) ? x3 + 16'h1000 : x3 + 16'h0800;
    v4 = 21'h010000 + {1'b0, rep_rlo};
    case (rep_len_m1)
      LEN1: c_fix = rep_c;
      LEN2: c_fix = (rep_c[10:0] < 11'h080) ? {10'b0, v2} : rep_c;
      LEN3: c_fix = (rep_c[15:0] < 16'h0800 ||
                     (rep_c[15:0] >= 16'hD800 && rep_c[15:0] < 16'hE000)) ?
                    {5'b0, v3} : rep_c;
      LEN4: c_fix = (rep_c < 21'h010000 || rep_c > 21'h10FFFF) ? v4 : rep_c;
      default: c_fix = rep_c;
    endcase

    enc[0] = {1'b0, c_fix[6:0]};
    enc[1] = 8'h00;
    enc[2] = 8'h00;
    enc[3] = 8'h00;
    case (rep_len_m1)
      LEN1: enc[0] = {1'b0, c_fix[6:0]};
      LEN2: begin
        enc[0] = LEAD2 | {3'b000, c_fix[10:6]};
        enc[1] = CONT_TAG | {2'b00, c_fix[5:0]};
      end
      LEN3: begin
        enc[0] = LEAD3 | {4'h0, c_fix[15:12]};
        enc[1] = CONT_TAG | {2'b00, c_fix[11:6]};
        enc[2] = CONT_TAG | {2'b00, c_fix[5:0]};
      end
      LEN4: begin
        enc[0] = LEAD4 | {5'b00000, c_fix[20:18]};
        enc[1] = CONT_TAG | {2'b00, c_fix[17:12]};
        enc[2] = CONT_TAG | {2'b00, c_fix[11:6]};
        enc[3] = CONT_TAG | {2'b00, c_fix[5:0]};
      end
      default: enc[0] = {1'b0, c_fix[6:0]};
    endcase

    for (int i = 0; i < 4; i++) begin
      ld_bytes[i] = enc[i];
    end
    ld_bytes[4] = 8'h00;
    if (rep_has_tail) begin
      ld_bytes[{1'b0, rep_len_m1} + 3'd1] = {1'b0, rep_tail};
    end
    ld_last = {1'b0, rep_len_m1} + {2'b00, rep_has_tail};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      ser_idx <= 3'd0;
    end else if (ser_load) begin
      ser_valid <= 1'b1;
      ser_idx <= 3'd0;
    end else if (ser_valid && out_ready) begin
      if (ser_at_last) begin
        ser_valid <= 1'b0;
      end else begin
        ser_idx <= ser_idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ser_load) begin
      for (int i = 0; i < SER_SLOTS; i++) begin
        ser_bytes[i] <= ld_bytes[i];
      end
      ser_last <= ld_last;
      ser_final <= rep_final;
    end
  end

  assign out_valid = ser_valid;
  assign out_byte = ser_bytes[ser_idx];
  assign run_last = ser_at_last;
  assign final_byte = ser_final && ser_at_last;

endmodule

>>> tb/utf8_sequence_repair_core_test.sv
`timescale 1ns / 1ps
module utf8_sequence_repair_core_test;
  import urep_pkg::*;

  localparam int IDLE_PCT = 26;
  localparam int STALL_CYCLES = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] out_byte;
    logic run_last;
    logic final_byte;
  } repaired_byte_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_byte;
  logic [31:0] random_word;
  logic string_end;
  logic out_valid;
  logic out_ready;
  logic [7:0] out_byte;
  logic run_last;
  logic final_byte;

  repaired_byte_t expected_bytes[$];
  logic [2:0][7:0] grp_bytes;
  int grp_count;
  logic [31:0] grp_random;

  int idle_pct = IDLE_PCT;
  int items_sent = 0;
  int bytes_checked = 0;
  int mismatches = 0;
  int stall_requests = 0;

  utf8_sequence_repair_core dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .random_word(random_word),
    .string_end(string_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte),
    .run_last(run_last),
    .final_byte(final_byte)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int encode_group(input logic [3:0][7:0] g, input int n,
                                      input logic [31:0] rnd);
    logic [31:0] cp;
    logic [7:0] lead_tag;
    logic [3:0][7:0] enc;
    repaired_byte_t rb;
    cp = {24'd0, g[0]};
    for (int i = 1; i < n; i++) begin
      cp = (cp << 6) + {26'd0, g[i][5:0]};
    end
    lead_tag = 8'h00;
    case (n)
      1: begin
        cp = cp & 32'h7F;
      end
      2: begin
        cp = cp & 32'h7FF;
        if (cp < 32'h80) begin
          cp = 32'h80 + rnd % 32'h780;
        end
        lead_tag = LEAD2;
      end
      3: begin
        cp = cp & 32'hFFFF;
        if (cp < 32'h800 || (cp >= 32'hD800 && cp < 32'hE000)) begin
          cp = 32'h800 + rnd % 32'hF000;
          // skip the surrogate gap
          if (cp >= 32'hD800) begin
            cp = cp + 32'h800;
          end
        end
        lead_tag = LEAD3;
      end
      default: begin
        cp = cp & 32'h1FFFFF;
        if (cp < 32'h10000 || cp > 32'h10FFFF) begin
          cp = 32'h10000 + rnd % 32'h100000;
        end
        lead_tag = LEAD4;
      end
    endcase
    enc = '0;
    for (int i = n - 1; i > 0; i--) begin
      enc[i] = CONT_TAG | {2'b00, cp[5:0]};
      cp = cp >> 6;
    end
    enc[0] = lead_tag | cp[7:0];
    for (int i = 0; i < n; i++) begin
      rb.out_byte = enc[i];
      rb.run_last = 1'b0;
      rb.final_byte = 1'b0;
      expected_bytes.push_back(rb);
    end
    return n;
  endfunction

  function automatic void predict_repair(input logic [7:0] b, input logic [31:0] r,
                                         input logic e);
    logic cont;
    logic [3:0][7:0] g;
    int k;
    int n;
    cont = (b & CONT_MASK) == CONT_TAG;
    k = 0;
    g = {8'h00, grp_bytes};
    if (grp_count > 0 && cont) begin
      g[grp_count] = b;
      n = grp_count + 1;
      if (n == 4 || e) begin
        k += encode_group(g, n, grp_random);
        grp_count = 0;
      end else begin
        grp_bytes[n - 1] = b;
        grp_count = n;
      end
    end else begin
      if (grp_count > 0) begin
        k += encode_group(g, grp_count, grp_random);
      end
      grp_random = r;
      if (e) begin
        g[0] = b;
        k += encode_group(g, 1, r);
        grp_count = 0;
      end else begin
        grp_bytes[0] = b;
        grp_count = 1;
      end
    end
    if (k > 0) begin
      expected_bytes[expected_bytes.size() - 1].run_last = 1'b1;
      if (e) begin
        expected_bytes[expected_bytes.size() - 1].final_byte = 1'b1;
      end
    end
  endfunction

  // called on a rising edge; returns on the edge that takes the beat
  task automatic send_byte(input logic [7:0] b, input logic [31:0] r, input logic e);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    random_word <= r;
    string_end <= e;
    do begin
      @(posedge clk);
    end while (!in_ready);
    predict_repair(b, r, e);
    items_sent++;
  endtask

  task automatic send_random_string();
    logic [7:0] str[$];
    int chars;
    int kind;
    int extra;
    chars = $urandom_range(1, 6);
    for (int c = 0; c < chars; c++) begin
      kind = $urandom_range(99);
      extra = 0;
      if (kind < 35) begin
        str.push_back({1'b0, 7'($urandom)});
      end else if (kind < 55) begin
        str.push_back({3'b110, 5'($urandom)});
        extra = 1;
      end else if (kind < 75) begin
        str.push_back({4'b1110, 4'($urandom)});
        extra = 2;
      end else if (kind < 90) begin
        str.push_back({5'b11110, 3'($urandom)});
        extra = 3;
      end else begin
        // broken sequence: any first byte, zero to five continuations
        str.push_back(8'($urandom));
        extra = $urandom_range(0, 5);
      end
      for (int i = 0; i < extra; i++) begin
        str.push_back({2'b10, 6'($urandom)});
      end
    end
    for (int i = 0; i < str.size(); i++) begin
      send_byte(str[i], $urandom, i == str.size() - 1);
    end
  endtask

  task automatic send_random_mix(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) < 8) begin
        send_random_string();
      end else begin
        send_byte(8'($urandom), $urandom, $urandom_range(7) == 0);
      end
    end
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic test_single_bytes();
    send_byte(8'h00, 32'h0000_0000, 1'b1);
    send_byte(8'h7F, 32'hFFFF_FFFF, 1'b1);
    send_byte(8'hFF, $urandom, 1'b1);
    // stray continuation opens its own group
    send_byte(8'h80, $urandom, 1'b1);
  endtask

  task automatic test_two_byte();
    send_byte(8'hC3, $urandom, 1'b0);
    send_byte(8'hA9, $urandom, 1'b1);
    send_byte(8'hC0, 32'h0000_0000, 1'b0);
    send_byte(8'h80, $urandom, 1'b1);
    send_byte(8'hC1, 32'hFFFF_FFFF, 1'b0);
    send_byte(8'hBF, $urandom, 1'b1);
  endtask

  task automatic test_three_byte();
    send_byte(8'hE2, $urandom, 1'b0);
    send_byte(8'h82, $urandom, 1'b0);
    send_byte(8'hAC, $urandom, 1'b1);
    // surrogate, replacement lands on the gap edge
    send_byte(8'hED, 32'h0000_D000, 1'b0);
    send_byte(8'hA0, $urandom, 1'b0);
    send_byte(8'h80, $urandom, 1'b1);
  endtask

  task automatic test_four_byte();
    send_byte(8'hF0, $urandom, 1'b0);
    send_byte(8'h9F, $urandom, 1'b0);
    send_byte(8'h98, $urandom, 1'b0);
    send_byte(8'h80, $urandom, 1'b0);
    send_byte(8'hF7, 32'hFFFF_FFFF, 1'b0);
    send_byte(8'hBF, $urandom, 1'b0);
    send_byte(8'hBF, $urandom, 1'b0);
    send_byte(8'hBF, $urandom, 1'b1);
  endtask

  task automatic test_open_group_close();
    send_byte(8'hC3, $urandom, 1'b0);
    send_byte(8'h41, $urandom, 1'b0);
    send_byte(8'hE2, $urandom, 1'b0);
    send_byte(8'h82, $urandom, 1'b1);
  endtask

  task automatic test_random_strings();
    send_random_mix(250);
    send_random_string();
  endtask

  task automatic test_full_rate();
    idle_pct = 0;
    send_random_mix(60);
    send_random_string();
    idle_pct = IDLE_PCT;
  endtask

  task automatic test_output_backpressure();
    stall_requests++;
    send_random_mix(60);
    send_random_string();
  endtask

  task automatic test_drain_pause();
    send_random_mix(15);
    send_random_string();
    wait_all_results();
    send_random_mix(15);
    send_random_string();
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_byte <= 8'h00;
    random_word <= 32'h0;
    string_end <= 1'b0;
    grp_bytes = '0;
    grp_count = 0;
    grp_random = 32'h0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_single_bytes();
    test_two_byte();
    test_three_byte();
    test_four_byte();
    test_open_group_close();
    test_random_strings();
    test_full_rate();
    test_output_backpressure();
    test_drain_pause();
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d input beats, checked %0d output beats", items_sent, bytes_checked);
    $display("covered all group lengths, repairs, full rate, a long output stall and a pause");
    if (mismatches == 0) begin
      $display("utf8_sequence_repair_core test passed");
    end else begin
      $display("utf8_sequence_repair_core test failed");
    end
    $finish;
  end

  // output side: check each beat, then decide out_ready for the next cycle
  initial begin : receiver
    repaired_byte_t want;
    int stall_left;
    int stall_served;
    stall_left = 0;
    stall_served = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (out_valid && out_ready) begin
          if (expected_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("unexpected output beat: byte %h run_last %b final_byte %b",
                       out_byte, run_last, final_byte);
            end
          end else begin
            want = expected_bytes.pop_front();
            if (want.out_byte !== out_byte || want.run_last !== run_last ||
                want.final_byte !== final_byte) begin
              mismatches++;
              if (mismatches <= 10) begin
                $display("mismatch at output beat %0d: expected %h/%b/%b, got %h/%b/%b",
                         bytes_checked, want.out_byte, want.run_last, want.final_byte,
                         out_byte, run_last, final_byte);
              end
            end
            bytes_checked++;
          end
        end
        if (stall_served != stall_requests) begin
          stall_served = stall_requests;
          stall_left = STALL_CYCLES;
        end
        if (stall_left > 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else begin
          out_ready <= ($urandom_range(99) >= idle_pct);
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("no beat moved for %0d cycles", QUIET_LIMIT);
    $display("utf8_sequence_repair_core test failed");
    $finish;
  end

endmodule

>>> sim.f
hdl/urep_pkg.sv
hdl/urep_front.sv
hdl/urep_queue.sv
hdl/urep_back.sv
hdl/utf8_sequence_repair_core.sv
tb/utf8_sequence_repair_core_test.sv
